// ===== hw/rtl/qau_pkg.sv =====
// Shared types and constants of the quaternion arithmetic unit.
package qau_pkg;

	// Operation codes as they arrive in the kind field of an input item.
	localparam logic [2:0] KIND_ADD   = 3'd0;
	localparam logic [2:0] KIND_SUB   = 3'd1;
	localparam logic [2:0] KIND_MUL   = 3'd2;
	localparam logic [2:0] KIND_SCALE = 3'd3;
	localparam logic [2:0] KIND_CONJ  = 3'd4;
	localparam logic [2:0] KIND_NORM  = 3'd5;

	// Operation class chosen by the front end; unused kinds pass A through.
	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_SCALE = 3'd3,
		OP_CONJ  = 3'd4,
		OP_NORM  = 3'd5,
		OP_PASS  = 3'd6
	} op_t;

	localparam int OP_BITS = 3;

	// Hamilton product: bit j of row k is set when term a[j]*b[j^k] is subtracted.
	localparam logic [3:0] MUL_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	// Handshake between the execute stage and the normalize unit.
	typedef struct packed {
		logic start;
		logic ack;
	} nrm_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} nrm_sts_t;

endpackage

// ===== hw/rtl/qau_in_if.sv =====
// Input channel of the quaternion arithmetic unit: operation and operands.
interface qau_in_if #(
	parameter int COMP_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   kind;
	logic signed [COMP_WIDTH-1:0] a_w;
	logic signed [COMP_WIDTH-1:0] a_x;
	logic signed [COMP_WIDTH-1:0] a_y;
	logic signed [COMP_WIDTH-1:0] a_z;
	logic signed [COMP_WIDTH-1:0] b_w;
	logic signed [COMP_WIDTH-1:0] b_x;
	logic signed [COMP_WIDTH-1:0] b_y;
	logic signed [COMP_WIDTH-1:0] b_z;
	logic signed [COMP_WIDTH-1:0] factor;

	modport source (
		output valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor,
		input  ready
	);

	modport sink (
		input  valid, kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor,
		output ready
	);
endinterface

// ===== hw/rtl/qau_out_if.sv =====
// Output channel of the quaternion arithmetic unit: result quaternion and flags.
interface qau_out_if #(
	parameter int COMP_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [COMP_WIDTH-1:0] r_w;
	logic signed [COMP_WIDTH-1:0] r_x;
	logic signed [COMP_WIDTH-1:0] r_y;
	logic signed [COMP_WIDTH-1:0] r_z;
	logic                         saturated;
	logic                         zero_norm;

	modport source (
		output valid, r_w, r_x, r_y, r_z, saturated, zero_norm,
		input  ready
	);

	modport sink (
		input  valid, r_w, r_x, r_y, r_z, saturated, zero_norm,
		output ready
	);
endinterface

// ===== hw/rtl/qau_front.sv =====
// Front end: accepts input items, decodes the operation and packs a queue entry.
module qau_front #(
	parameter int COMP_WIDTH = 32
) (
	qau_in_if.sink                          in_ch,
	input  logic                            full,
	output logic                            push,
	output logic [9*COMP_WIDTH+qau_pkg::OP_BITS-1:0] entry
);

	qau_pkg::op_t op;

	always_comb begin
		case (in_ch.kind)
			qau_pkg::KIND_ADD:   op = qau_pkg::OP_ADD;
			qau_pkg::KIND_SUB:   op = qau_pkg::OP_SUB;
			qau_pkg::KIND_MUL:   op = qau_pkg::OP_MUL;
			qau_pkg::KIND_SCALE: op = qau_pkg::OP_SCALE;
			qau_pkg::KIND_CONJ:  op = qau_pkg::OP_CONJ;
			qau_pkg::KIND_NORM:  op = qau_pkg::OP_NORM;
			default:             op = qau_pkg::OP_PASS;
		endcase
	end

	assign in_ch.ready = !full;
	assign push        = in_ch.valid && !full;

	// Component 0 of A sits at the bottom, the operation on top.
	assign entry = {op, in_ch.factor,
		in_ch.b_z, in_ch.b_y, in_ch.b_x, in_ch.b_w,
		in_ch.a_z, in_ch.a_y, in_ch.a_x, in_ch.a_w};

endmodule

// ===== hw/rtl/qau_fifo.sv =====
// Short queue that decouples the front end from the execute stages.
module qau_fifo #(
	parameter int WIDTH = 291,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             nonempty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   count_q;

	assign full     = count_q == CNW'(DEPTH);
	assign nonempty = count_q != '0;
	assign rdata    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/qau_nrm.sv =====
// Normalize unit: bit-serial square root of the sum of squares, then four bit-serial divides side by side.
module qau_nrm #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qau_pkg::nrm_ctl_t            ctl,
	output qau_pkg::nrm_sts_t            sts,
	input  logic [2*COMP_WIDTH+1:0]      s_sum,
	input  logic signed [COMP_WIDTH-1:0] a [4],
	output logic signed [COMP_WIDTH-1:0] res [4],
	output logic                         sat,
	output logic                         zn
);

	localparam int CW   = COMP_WIDTH;
	localparam int FB   = FRAC_BITS;
	localparam int SW   = 2 * CW + 2;
	localparam int RW   = CW + 4;
	localparam int VW   = ((FB + 2 > CW) ? FB + 2 : CW) + 2;
	localparam int CNTW = $clog2(((CW > FB) ? CW : FB) + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQRT = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_DONE = 5'b10000
	} nrm_state_t;

	nrm_state_t      state_q;
	logic [CNTW-1:0] cnt_q;
	logic [SW-1:0]   sop_q;
	logic [RW-1:0]   srem_q;
	logic [CW:0]     root_q;
	logic [CW:0]     r_q [4];
	logic [FB:0]     q_q [4];
	logic            neg_q [4];
	logic signed [CW-1:0] res_q [4];
	logic            sat_q;
	logic            zn_q;

	logic [RW-1:0]   sx;
	logic [RW-1:0]   strial;
	logic            sge;
	logic [CW+1:0]   dx [4];
	logic            dge [4];
	logic [CW:0]     mag_in [4];
	logic [CW:0]     fin_cl [4];

	function automatic logic [CW:0] clamp(input logic signed [VW-1:0] v);
		logic [VW-CW:0] top;
		top = v[VW-1:CW-1];
		if (top == '0 || top == '1) begin
			return {1'b0, v[CW-1:0]};
		end else if (v[VW-1]) begin
			return {2'b11, {(CW-1){1'b0}}};
		end else begin
			return {2'b10, {(CW-1){1'b1}}};
		end
	endfunction

	// One step of the restoring square root: two radicand bits per step.
	assign sx     = {srem_q[RW-3:0], sop_q[SW-1:SW-2]};
	assign strial = {{(RW-CW-3){1'b0}}, root_q, 2'b01};
	assign sge    = sx >= strial;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			logic [FB+1:0]        mag_f;
			logic signed [VW-1:0] v;
			logic                 up;
			mag_in[i] = {1'b0, (a[i][CW-1] ? (~a[i] + CW'(1)) : a[i])};
			// The first divide step takes the magnitude as it is, later steps shift.
			dx[i]  = (cnt_q == '0) ? {1'b0, r_q[i]} : {r_q[i], 1'b0};
			dge[i] = dx[i] >= {1'b0, root_q};
			// Round to nearest, ties away from zero, on the magnitude.
			up     = {r_q[i], 1'b0} >= {1'b0, root_q};
			mag_f  = {1'b0, q_q[i]} + (FB + 2)'(up);
			v      = VW'({{(VW-FB-2){1'b0}}, mag_f});
			if (neg_q[i]) begin
				v = -v;
			end
			fin_cl[i] = clamp(v);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (ctl.start) begin
						state_q <= (s_sum == '0) ? ST_DONE : ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == CNTW'(CW)) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				ST_DIV: begin
					if (cnt_q == CNTW'(FB)) begin
						cnt_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (ctl.ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					sop_q  <= s_sum;
					srem_q <= '0;
					root_q <= '0;
					sat_q  <= 1'b0;
					zn_q   <= s_sum == '0;
					for (int i = 0; i < 4; i++) begin
						r_q[i]   <= mag_in[i];
						q_q[i]   <= '0;
						neg_q[i] <= a[i][CW-1];
						res_q[i] <= a[i];
					end
				end
			end
			ST_SQRT: begin
				sop_q  <= sop_q << 2;
				srem_q <= sge ? sx - strial : sx;
				root_q <= {root_q[CW-1:0], sge};
			end
			ST_DIV: begin
				for (int i = 0; i < 4; i++) begin
					r_q[i] <= dge[i] ? (CW + 1)'(dx[i] - {1'b0, root_q}) : dx[i][CW:0];
					q_q[i] <= {q_q[i][FB-1:0], dge[i]};
				end
			end
			ST_FIN: begin
				for (int i = 0; i < 4; i++) begin
					res_q[i] <= fin_cl[i][CW-1:0];
				end
				sat_q <= fin_cl[0][CW] | fin_cl[1][CW] | fin_cl[2][CW] | fin_cl[3][CW];
				zn_q  <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign sts.idle = state_q == ST_IDLE;
	assign sts.done = state_q == ST_DONE;
	assign res      = res_q;
	assign sat      = sat_q;
	assign zn       = zn_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("normalize started while the unit was busy");
	a_zero_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start && s_sum == '0 |=> state_q == ST_DONE && zn_q)
		else $error("zero norm did not finish at once with its flag");
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> root_q != '0)
		else $error("divide started with a zero root");
	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ack |-> state_q == ST_DONE)
		else $error("normalize result taken before it was finished");
`endif

endmodule

// ===== hw/rtl/qau_back.sv =====
// Execute stages: multiplier array, then combine, round, saturate and output register.
module qau_back #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 28
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [9*COMP_WIDTH+qau_pkg::OP_BITS-1:0] rd_data,
	input  logic                                     rd_valid,
	output logic                                     pop,
	output qau_pkg::nrm_ctl_t                        nrm_ctl,
	input  qau_pkg::nrm_sts_t                        nrm_sts,
	output logic [2*COMP_WIDTH+1:0]                  s_sum,
	output logic signed [COMP_WIDTH-1:0]             nrm_a [4],
	input  logic signed [COMP_WIDTH-1:0]             nrm_res [4],
	input  logic                                     nrm_sat,
	input  logic                                     nrm_zn,
	qau_out_if.source                                out_ch
);

	localparam int CW = COMP_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int PW = 2 * CW;
	localparam int WB = 2 * CW + 3;
	localparam int SW = 2 * CW + 2;
	localparam logic signed [WB-1:0] HALF = {{(WB-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

	function automatic logic signed [WB-1:0] sx1(input logic signed [CW-1:0] v);
		return {{(WB-CW){v[CW-1]}}, v};
	endfunction

	function automatic logic signed [WB-1:0] sx2(input logic signed [PW-1:0] v);
		return {{(WB-PW){v[PW-1]}}, v};
	endfunction

	function automatic logic [CW:0] clamp(input logic signed [WB-1:0] v);
		logic [WB-CW:0] top;
		top = v[WB-1:CW-1];
		if (top == '0 || top == '1) begin
			return {1'b0, v[CW-1:0]};
		end else if (v[WB-1]) begin
			return {2'b11, {(CW-1){1'b0}}};
		end else begin
			return {2'b10, {(CW-1){1'b1}}};
		end
	endfunction

	qau_pkg::op_t         in_op;
	logic signed [CW-1:0] in_a [4];
	logic signed [CW-1:0] in_b [4];
	logic signed [CW-1:0] in_f;
	logic signed [CW-1:0] mul_y [4][4];

	logic                 valid_s1;
	qau_pkg::op_t         op_s1;
	logic signed [CW-1:0] a_s1 [4];
	logic signed [CW-1:0] b_s1 [4];
	logic signed [PW-1:0] p_s1 [4][4];

	logic signed [WB-1:0] msum [4];
	logic signed [WB-1:0] val [4];
	logic [CW:0]          cl [4];

	logic                 out_v_q;
	logic signed [CW-1:0] r_q [4];
	logic                 sat_q;
	logic                 zn_q;

	logic                 out_free;
	logic                 is_norm;
	logic                 fire_s1;
	logic                 advance_s1;

	assign in_op = qau_pkg::op_t'(rd_data[9*CW +: qau_pkg::OP_BITS]);
	assign in_f  = rd_data[8*CW +: CW];

	// Multiplier operands: row k, lane j forms a[j] times b[j^k] for the product,
	// row 0 forms a[j]*factor for scale and a[j]^2 for normalize.
	for (genvar j = 0; j < 4; j++) begin : g_lane
		assign in_a[j] = rd_data[j*CW +: CW];
		assign in_b[j] = rd_data[(4+j)*CW +: CW];
		for (genvar k = 0; k < 4; k++) begin : g_row
			localparam int J = j ^ k;
			if (k == 0) begin : g_first
				always_comb begin
					case (in_op)
						qau_pkg::OP_SCALE: mul_y[k][j] = in_f;
						qau_pkg::OP_NORM:  mul_y[k][j] = in_a[j];
						default:           mul_y[k][j] = in_b[J];
					endcase
				end
			end else begin : g_other
				assign mul_y[k][j] = in_b[J];
			end
		end
	end

	assign is_norm    = op_s1 == qau_pkg::OP_NORM;
	assign out_free   = !out_v_q || out_ch.ready;
	assign fire_s1    = valid_s1 && out_free && (!is_norm || nrm_sts.done);
	assign advance_s1 = !valid_s1 || fire_s1;
	assign pop        = advance_s1 && rd_valid;

	assign nrm_ctl.start = valid_s1 && is_norm && nrm_sts.idle;
	assign nrm_ctl.ack   = fire_s1 && is_norm;
	assign nrm_a         = a_s1;

	always_comb begin
		s_sum = '0;
		for (int j = 0; j < 4; j++) begin
			s_sum = s_sum + {2'b00, p_s1[0][j]};
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			msum[k] = HALF;
			for (int j = 0; j < 4; j++) begin
				if (qau_pkg::MUL_NEG[k][j]) begin
					msum[k] = msum[k] - sx2(p_s1[k][j]);
				end else begin
					msum[k] = msum[k] + sx2(p_s1[k][j]);
				end
			end
			case (op_s1)
				qau_pkg::OP_ADD:   val[k] = sx1(a_s1[k]) + sx1(b_s1[k]);
				qau_pkg::OP_SUB:   val[k] = sx1(a_s1[k]) - sx1(b_s1[k]);
				qau_pkg::OP_MUL:   val[k] = msum[k] >>> FB;
				qau_pkg::OP_SCALE: val[k] = (sx2(p_s1[0][k]) + HALF) >>> FB;
				qau_pkg::OP_CONJ:  val[k] = (k == 0) ? sx1(a_s1[k]) : -sx1(a_s1[k]);
				default:           val[k] = sx1(a_s1[k]);
			endcase
			cl[k] = clamp(val[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (advance_s1) begin
				valid_s1 <= rd_valid;
			end
			if (fire_s1) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= in_op;
			for (int j = 0; j < 4; j++) begin
				a_s1[j] <= in_a[j];
				b_s1[j] <= in_b[j];
				for (int k = 0; k < 4; k++) begin
					p_s1[k][j] <= PW'(in_a[j]) * PW'(mul_y[k][j]);
				end
			end
		end
		if (fire_s1) begin
			if (is_norm) begin
				r_q   <= nrm_res;
				sat_q <= nrm_sat;
				zn_q  <= nrm_zn;
			end else begin
				for (int k = 0; k < 4; k++) begin
					r_q[k] <= cl[k][CW-1:0];
				end
				sat_q <= cl[0][CW] | cl[1][CW] | cl[2][CW] | cl[3][CW];
				zn_q  <= 1'b0;
			end
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.r_w       = r_q[0];
	assign out_ch.r_x       = r_q[1];
	assign out_ch.r_y       = r_q[2];
	assign out_ch.r_z       = r_q[3];
	assign out_ch.saturated = sat_q;
	assign out_ch.zero_norm = zn_q;

endmodule

// ===== hw/rtl/quaternion_arithmetic_unit_core.sv =====
// Top level of the quaternion arithmetic unit in signed fixed point.
//
//   channel  direction  handshake      item
//   in_ch    sink       valid/ready    kind, A (a_w..a_z), B (b_w..b_z), factor
//   out_ch   source     valid/ready    r_w..r_z, saturated, zero_norm
//
// Add, subtract, Hamilton product, scale, conjugate and the unused kinds
// take one item per cycle while the output is not stalled and no normalize
// holds the execute stage; an accepted item passes through the queue, the
// multiplier stage and the output register. Normalize holds the execute stage
// while the normalize unit runs its one-bit-per-cycle square root and divide
// loop; items behind it wait in the queue and keep their order.
// Reset (arst_n low) empties the queue, the pipeline and the output register.
// A stalled output keeps its item while the queue still takes new items
// until it is full.
module quaternion_arithmetic_unit_core #(
	parameter int FRAC_BITS   = 28,
	parameter int COMP_WIDTH  = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	qau_in_if.sink    in_ch,
	qau_out_if.source out_ch
);

	// A queue entry holds the decoded operation and the nine operand words.
	localparam int EW = 9 * COMP_WIDTH + qau_pkg::OP_BITS;

	logic                         push;
	logic [EW-1:0]                entry;
	logic                         full;
	logic                         pop;
	logic [EW-1:0]                rd_data;
	logic                         rd_valid;
	qau_pkg::nrm_ctl_t            nrm_ctl;
	qau_pkg::nrm_sts_t            nrm_sts;
	logic [2*COMP_WIDTH+1:0]      s_sum;
	logic signed [COMP_WIDTH-1:0] nrm_a [4];
	logic signed [COMP_WIDTH-1:0] nrm_res [4];
	logic                         nrm_sat;
	logic                         nrm_zn;

	// Front end: takes an item whenever the queue has room.
	qau_front #(
		.COMP_WIDTH (COMP_WIDTH)
	) u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.entry (entry)
	);

	qau_fifo #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (entry),
		.full     (full),
		.pop      (pop),
		.rdata    (rd_data),
		.nonempty (rd_valid)
	);

	// Normalize unit: square root of the sum of squares, then the divides.
	qau_nrm #(
		.COMP_WIDTH (COMP_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_nrm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (nrm_ctl),
		.sts    (nrm_sts),
		.s_sum  (s_sum),
		.a      (nrm_a),
		.res    (nrm_res),
		.sat    (nrm_sat),
		.zn     (nrm_zn)
	);

	// Back end: multiplier stage, combine logic and the output register.
	qau_back #(
		.COMP_WIDTH (COMP_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_data  (rd_data),
		.rd_valid (rd_valid),
		.pop      (pop),
		.nrm_ctl  (nrm_ctl),
		.nrm_sts  (nrm_sts),
		.s_sum    (s_sum),
		.nrm_a    (nrm_a),
		.nrm_res  (nrm_res),
		.nrm_sat  (nrm_sat),
		.nrm_zn   (nrm_zn),
		.out_ch   (out_ch)
	);

endmodule
